@@ design/json_string_unescape_utf8_top_assert.svh @@
// ----------------------------------------------------------------------------
// json string unescape assertion macros
// shared property forms for the decoder checks
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_ASSERT_SVH

// same-cycle implication, held off while in reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// types, character codes and helper functions of the json string decoder
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // decoder mode
  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_ESC     = 3'd1,
    M_HEX1    = 3'd2,
    M_WANT_BS = 3'd3,
    M_WANT_U  = 3'd4,
    M_HEX2    = 3'd5,
    M_STOP    = 3'd6,
    M_FAIL    = 3'd7
  } mode_t;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_ESC = 3'd1;
  localparam logic [2:0] ST_BAD_HEX = 3'd2;
  localparam logic [2:0] ST_NO_LOW  = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  // character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // control bytes that escapes stand for
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // surrogate pair offset
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // most bytes one input byte can produce
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    logic [MAX_RES-1:0][7:0]  bytes;
  } utf8_seq_t;

  // one ascii hex digit, either case
  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // code point to utf-8, first byte in lane 0
  function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
    utf8_seq_t r;
    r.bytes = '0;
    if (cp <= 21'h7F) begin
      r.cnt      = CNT_W'(1);
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.cnt      = CNT_W'(2);
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.cnt      = CNT_W'(3);
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt      = CNT_W'(4);
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/json_string_unescape_utf8_top.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// streaming decoder for a json string body, emitting utf-8 bytes
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle when ready and decodes it against the escape
// state in a single pass into a result register holding up to four output
// words. A byte that yields k results (k from 0 to 4) drains them one word
// per cycle while out_tready is high; a byte with no result, or one taken
// result, lets the next byte enter in the following cycle, so plain text runs
// at one byte per clock. Only the completion of a \u escape outside ascii
// produces two to four words. Errors give one word with the valid flag clear
// and a status code; a quote or an error silences the rest of the string,
// and the byte marked by in_tlast returns the decoder to its reset state.
`default_nettype none

module json_string_unescape_utf8_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // end_of_string
  // result stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [3:0]      out_tuser,  // [0] out_valid, [3:1] status
  output logic            out_tlast   // last
);

  localparam int CW = jsu_pkg::CNT_W;

  // decoder state
  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     hex_cnt_r, hex_cnt_nxt;
  logic [11:0]    hex_acc_r, hex_acc_nxt;
  logic [9:0]     high_r, high_nxt;

  // result register
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [jsu_pkg::MAX_RES-1:0][7:0] bytes_r, bytes_nxt;
  logic                            err_r, err_nxt;
  logic [2:0]                      status_r, status_nxt;

  // results of the current byte
  logic [CW-1:0]                   res_cnt;
  logic [jsu_pkg::MAX_RES-1:0][7:0] res_bytes;
  logic                            res_err;
  logic [2:0]                      res_status;

  logic                 in_acc, out_acc;
  jsu_pkg::hex_digit_t  hd;
  logic [15:0]          word;
  logic [20:0]          cp_pair, cp_sel;
  jsu_pkg::utf8_seq_t   enc;

  // handshakes
  assign out_tvalid = (cnt_r != '0);
  assign out_acc    = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == '0) || ((cnt_r == CW'(1)) && out_tready);
  assign in_acc     = in_tvalid && in_tready;

  // hex digit and code point paths
  assign hd      = jsu_pkg::hex_digit(in_tdata);
  assign word    = {hex_acc_r, hd.val};
  assign cp_pair = jsu_pkg::SUPP_BASE + {1'b0, high_r, word[9:0]};
  assign cp_sel  = (mode_r == jsu_pkg::M_HEX2) ? cp_pair : {5'd0, word};
  assign enc     = jsu_pkg::utf8_encode(cp_sel);

  // decode one byte
  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    hex_acc_nxt = hex_acc_r;
    high_nxt    = high_r;
    res_cnt     = '0;
    res_bytes   = '0;
    res_err     = 1'b0;
    res_status  = jsu_pkg::ST_OK;
    case (mode_r)
      jsu_pkg::M_NORMAL: begin
        if (in_tdata == jsu_pkg::CH_QUOTE) begin
          mode_nxt = jsu_pkg::M_STOP;
        end else if (in_tdata == jsu_pkg::CH_BSL) begin
          mode_nxt = jsu_pkg::M_ESC;
        end else begin
          res_cnt      = CW'(1);
          res_bytes[0] = in_tdata;
        end
      end
      jsu_pkg::M_ESC: begin
        mode_nxt = jsu_pkg::M_NORMAL;
        res_cnt  = CW'(1);
        case (in_tdata)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH, jsu_pkg::CH_BSL: begin
            res_bytes[0] = in_tdata;
          end
          jsu_pkg::CH_B: res_bytes[0] = jsu_pkg::BYTE_BS;
          jsu_pkg::CH_F: res_bytes[0] = jsu_pkg::BYTE_FF;
          jsu_pkg::CH_N: res_bytes[0] = jsu_pkg::BYTE_LF;
          jsu_pkg::CH_R: res_bytes[0] = jsu_pkg::BYTE_CR;
          jsu_pkg::CH_T: res_bytes[0] = jsu_pkg::BYTE_TAB;
          jsu_pkg::CH_U: begin
            res_cnt     = '0;
            mode_nxt    = jsu_pkg::M_HEX1;
            hex_cnt_nxt = 2'd0;
            hex_acc_nxt = '0;
          end
          default: begin
            mode_nxt   = jsu_pkg::M_FAIL;
            res_err    = 1'b1;
            res_status = jsu_pkg::ST_BAD_ESC;
          end
        endcase
      end
      jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
        if (!hd.ok) begin
          mode_nxt   = jsu_pkg::M_FAIL;
          res_cnt    = CW'(1);
          res_err    = 1'b1;
          res_status = jsu_pkg::ST_BAD_HEX;
        end else begin
          hex_acc_nxt = word[11:0];
          if (hex_cnt_r != 2'd3) begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end else begin
            hex_cnt_nxt = 2'd0;
            // high surrogate waits for its partner escape
            if (mode_r == jsu_pkg::M_HEX1 && word[15:10] == 6'b110110) begin
              high_nxt = word[9:0];
              mode_nxt = jsu_pkg::M_WANT_BS;
            end else begin
              mode_nxt  = jsu_pkg::M_NORMAL;
              res_cnt   = enc.cnt;
              res_bytes = enc.bytes;
            end
          end
        end
      end
      jsu_pkg::M_WANT_BS: begin
        if (in_tdata == jsu_pkg::CH_BSL) begin
          mode_nxt = jsu_pkg::M_WANT_U;
        end else begin
          mode_nxt   = jsu_pkg::M_FAIL;
          res_cnt    = CW'(1);
          res_err    = 1'b1;
          res_status = jsu_pkg::ST_NO_LOW;
        end
      end
      jsu_pkg::M_WANT_U: begin
        if (in_tdata == jsu_pkg::CH_U) begin
          mode_nxt    = jsu_pkg::M_HEX2;
          hex_cnt_nxt = 2'd0;
          hex_acc_nxt = '0;
        end else begin
          mode_nxt   = jsu_pkg::M_FAIL;
          res_cnt    = CW'(1);
          res_err    = 1'b1;
          res_status = jsu_pkg::ST_NO_LOW;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase

    // end of string: flag an open escape, then back to reset state
    if (in_tlast) begin
      if (mode_nxt == jsu_pkg::M_ESC || mode_nxt == jsu_pkg::M_HEX1 ||
          mode_nxt == jsu_pkg::M_HEX2 || mode_nxt == jsu_pkg::M_WANT_BS ||
          mode_nxt == jsu_pkg::M_WANT_U) begin
        res_cnt    = CW'(1);
        res_bytes  = '0;
        res_err    = 1'b1;
        res_status = jsu_pkg::ST_TRUNC;
      end
      mode_nxt    = jsu_pkg::M_NORMAL;
      hex_cnt_nxt = 2'd0;
      hex_acc_nxt = '0;
      high_nxt    = '0;
    end
  end

  // result register load and drain
  always_comb begin
    cnt_nxt    = cnt_r;
    bytes_nxt  = bytes_r;
    err_nxt    = err_r;
    status_nxt = status_r;
    if (in_acc && res_cnt != '0) begin
      cnt_nxt    = res_cnt;
      bytes_nxt  = res_bytes;
      err_nxt    = res_err;
      status_nxt = res_status;
    end else if (out_acc) begin
      cnt_nxt   = cnt_r - CW'(1);
      bytes_nxt = {8'd0, bytes_r[jsu_pkg::MAX_RES-1:1]};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= jsu_pkg::M_NORMAL;
      hex_cnt_r <= 2'd0;
      hex_acc_r <= '0;
      high_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (in_acc) begin
        mode_r    <= mode_nxt;
        hex_cnt_r <= hex_cnt_nxt;
        hex_acc_r <= hex_acc_nxt;
        high_r    <= high_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bytes_r  <= bytes_nxt;
    err_r    <= err_nxt;
    status_r <= status_nxt;
  end

  // result word
  assign out_tdata = err_r ? 8'd0 : bytes_r[0];
  assign out_tuser = {status_r, ~err_r};
  assign out_tlast = (cnt_r == CW'(1));

  // checks
  `include "json_string_unescape_utf8_top_assert.svh"

  `JSU_ASSERT_NOW(a_no_accept_busy, cnt_r > CW'(1), !in_tready, "input taken over pending burst")
  `JSU_ASSERT_NOW(a_err_single, out_tvalid && err_r, cnt_r == CW'(1), "error result not alone")
  `JSU_ASSERT_NEXT(a_eos_reset, in_acc && in_tlast, mode_r == jsu_pkg::M_NORMAL && hex_cnt_r == 2'd0, "state not reset after end of string")
  `JSU_ASSERT_NOW(a_hex_cnt_mode, hex_cnt_r != 2'd0, mode_r == jsu_pkg::M_HEX1 || mode_r == jsu_pkg::M_HEX2 || mode_r == jsu_pkg::M_FAIL, "hex count outside hex or failed mode")

endmodule

`default_nettype wire

@@ tb/tb_json_string_unescape_utf8_top.sv @@
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_top
// self-checking bench for the streaming json string decoder
// ----------------------------------------------------------------------------
// Feeds escaped string bodies one byte per word. A short table of directed
// bytes comes first, then random strings built from plain bytes, simple
// escapes, \u escapes, surrogate pairs and broken tails (bad escape, bad hex,
// missing low half, quote, truncation). A behavioral decoder kept in the bench
// predicts every result word. The monitor pops the oldest prediction for each
// accepted word and compares it field by field. Both sides throttle at random,
// and the receiver holds off once for a long stretch so the input backs up.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS        = 220;
  localparam int LIMIT        = 100000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 16;

  // one result word: byte, valid flag, status, last flag
  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic [2:0] status;
    logic       tail;
  } word_t;

  // directed row: input byte, end flag, and a typed-in word where obvious
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    word_t      exp_w;
  } row_t;

  localparam word_t NOEXP = '0;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       out_tlast;

  // decoder model state
  jsu_pkg::mode_t dmode;
  logic [1:0]     hex_cnt;
  logic [15:0]    hex_acc;
  logic [9:0]     hi_half;
  logic [2:0]     err_code;

  word_t      step_q[$];
  word_t      decoded_q[$];
  logic [7:0] str_q[$];

  int errs       = 0;
  int cycles     = 0;
  int live_items = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;
  bit pressed    = 1'b0;

  logic [7:0] esc_set [0:7] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH, jsu_pkg::CH_BSL,
                                jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                                jsu_pkg::CH_R, jsu_pkg::CH_T};

  // directed bytes: extremes, an escape, a surrogate pair, errors but bad hex
  row_t dir_tab [0:29] = '{
    {8'h00,             1'b0, 1'b1, {8'h00, 1'b1, jsu_pkg::ST_OK, 1'b1}},
    {8'hFF,             1'b0, 1'b1, {8'hFF, 1'b1, jsu_pkg::ST_OK, 1'b1}},
    {jsu_pkg::CH_BSL,   1'b0, 1'b0, NOEXP},
    {jsu_pkg::CH_N,     1'b0, 1'b1, {jsu_pkg::BYTE_LF, 1'b1, jsu_pkg::ST_OK, 1'b1}},
    {jsu_pkg::CH_BSL,   1'b0, 1'b0, NOEXP},
    {jsu_pkg::CH_U,     1'b0, 1'b0, NOEXP},
    {"D",               1'b0, 1'b0, NOEXP},
    {"8",               1'b0, 1'b0, NOEXP},
    {"3",               1'b0, 1'b0, NOEXP},
    {"d",               1'b0, 1'b0, NOEXP},
    {jsu_pkg::CH_BSL,   1'b0, 1'b0, NOEXP},
    {jsu_pkg::CH_U,     1'b0, 1'b0, NOEXP},
    {"D",               1'b0, 1'b0, NOEXP},
    {"e",               1'b0, 1'b0, NOEXP},
    {"0",               1'b0, 1'b0, NOEXP},
    {"0",               1'b0, 1'b0, NOEXP},
    {jsu_pkg::CH_BSL,   1'b0, 1'b0, NOEXP},
    {"q",               1'b0, 1'b1, {8'h00, 1'b0, jsu_pkg::ST_BAD_ESC, 1'b1}},
    {"x",               1'b1, 1'b0, NOEXP},
    {jsu_pkg::CH_BSL,   1'b0, 1'b0, NOEXP},
    {jsu_pkg::CH_U,     1'b0, 1'b0, NOEXP},
    {"D",               1'b0, 1'b0, NOEXP},
    {"8",               1'b0, 1'b0, NOEXP},
    {"0",               1'b0, 1'b0, NOEXP},
    {"0",               1'b0, 1'b0, NOEXP},
    {"z",               1'b1, 1'b1, {8'h00, 1'b0, jsu_pkg::ST_NO_LOW, 1'b1}},
    {jsu_pkg::CH_QUOTE, 1'b0, 1'b0, NOEXP},
    {"a",               1'b0, 1'b0, NOEXP},
    {jsu_pkg::CH_BSL,   1'b1, 1'b0, NOEXP},
    {jsu_pkg::CH_BSL,   1'b1, 1'b1, {8'h00, 1'b0, jsu_pkg::ST_TRUNC, 1'b1}}
  };

  json_string_unescape_utf8_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ascii hex digit value, either case
  function automatic logic [3:0] hex_of(input logic [7:0] c, output bit ok);
    logic [7:0] t;
    ok = 1'b1;
    t  = 8'h00;
    if (c >= "0" && c <= "9") t = c - "0";
    else if (c >= "a" && c <= "f") t = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") t = c - "A" + 8'd10;
    else ok = 1'b0;
    return t[3:0];
  endfunction

  function automatic void put_word(input logic [7:0] b, input logic v, input logic [2:0] s);
    word_t w;
    w = {b, v, s, 1'b0};
    if (step_q.size() < jsu_pkg::MAX_RES) step_q.push_back(w);
  endfunction

  function automatic void set_fail(input logic [2:0] s);
    err_code = s;
    dmode    = jsu_pkg::M_FAIL;
    put_word(8'h00, 1'b0, s);
  endfunction

  // code point to one..four utf-8 bytes
  function automatic void put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_word(cp[7:0], 1'b1, jsu_pkg::ST_OK);
    end else if (cp <= 21'h7FF) begin
      put_word(8'hC0 | cp[10:6], 1'b1, jsu_pkg::ST_OK);
      put_word(8'h80 | cp[5:0], 1'b1, jsu_pkg::ST_OK);
    end else if (cp <= 21'hFFFF) begin
      put_word(8'hE0 | cp[15:12], 1'b1, jsu_pkg::ST_OK);
      put_word(8'h80 | cp[11:6], 1'b1, jsu_pkg::ST_OK);
      put_word(8'h80 | cp[5:0], 1'b1, jsu_pkg::ST_OK);
    end else begin
      put_word(8'hF0 | cp[20:18], 1'b1, jsu_pkg::ST_OK);
      put_word(8'h80 | cp[17:12], 1'b1, jsu_pkg::ST_OK);
      put_word(8'h80 | cp[11:6], 1'b1, jsu_pkg::ST_OK);
      put_word(8'h80 | cp[5:0], 1'b1, jsu_pkg::ST_OK);
    end
  endfunction

  function automatic void reset_decoder();
    dmode    = jsu_pkg::M_NORMAL;
    hex_cnt  = 2'd0;
    hex_acc  = 16'h0000;
    hi_half  = 10'h000;
    err_code = jsu_pkg::ST_OK;
  endfunction

  // decode one input byte into step_q
  function automatic void decode_byte(input logic [7:0] c, input logic eos);
    logic [3:0] d;
    bit         ok;
    step_q.delete();
    if (dmode != jsu_pkg::M_STOP && dmode != jsu_pkg::M_FAIL) live_items++;
    case (dmode)
      jsu_pkg::M_NORMAL: begin
        if (c == jsu_pkg::CH_QUOTE) dmode = jsu_pkg::M_STOP;
        else if (c == jsu_pkg::CH_BSL) dmode = jsu_pkg::M_ESC;
        else put_word(c, 1'b1, jsu_pkg::ST_OK);
      end
      jsu_pkg::M_ESC: begin
        dmode = jsu_pkg::M_NORMAL;
        case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH, jsu_pkg::CH_BSL:
            put_word(c, 1'b1, jsu_pkg::ST_OK);
          jsu_pkg::CH_B: put_word(jsu_pkg::BYTE_BS, 1'b1, jsu_pkg::ST_OK);
          jsu_pkg::CH_F: put_word(jsu_pkg::BYTE_FF, 1'b1, jsu_pkg::ST_OK);
          jsu_pkg::CH_N: put_word(jsu_pkg::BYTE_LF, 1'b1, jsu_pkg::ST_OK);
          jsu_pkg::CH_R: put_word(jsu_pkg::BYTE_CR, 1'b1, jsu_pkg::ST_OK);
          jsu_pkg::CH_T: put_word(jsu_pkg::BYTE_TAB, 1'b1, jsu_pkg::ST_OK);
          jsu_pkg::CH_U: begin
            dmode   = jsu_pkg::M_HEX1;
            hex_cnt = 2'd0;
            hex_acc = 16'h0000;
          end
          default: set_fail(jsu_pkg::ST_BAD_ESC);
        endcase
      end
      jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
        d = hex_of(c, ok);
        if (!ok) begin
          set_fail(jsu_pkg::ST_BAD_HEX);
        end else begin
          hex_acc = {hex_acc[11:0], d};
          if (hex_cnt != 2'd3) begin
            hex_cnt = hex_cnt + 2'd1;
          end else begin
            hex_cnt = 2'd0;
            if (dmode == jsu_pkg::M_HEX1) begin
              // high surrogate waits for its partner
              if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                hi_half = hex_acc[9:0];
                dmode   = jsu_pkg::M_WANT_BS;
              end else begin
                dmode = jsu_pkg::M_NORMAL;
                put_utf8({5'd0, hex_acc});
              end
            end else begin
              // second escape: only its low ten bits count
              dmode = jsu_pkg::M_NORMAL;
              put_utf8(jsu_pkg::SUPP_BASE + {1'b0, hi_half, hex_acc[9:0]});
            end
          end
        end
      end
      jsu_pkg::M_WANT_BS: begin
        if (c == jsu_pkg::CH_BSL) dmode = jsu_pkg::M_WANT_U;
        else set_fail(jsu_pkg::ST_NO_LOW);
      end
      jsu_pkg::M_WANT_U: begin
        if (c == jsu_pkg::CH_U) begin
          dmode   = jsu_pkg::M_HEX2;
          hex_cnt = 2'd0;
          hex_acc = 16'h0000;
        end else begin
          set_fail(jsu_pkg::ST_NO_LOW);
        end
      end
      default: ;
    endcase
    // end of string: unfinished escape is a truncation, then back to reset
    if (eos) begin
      if (dmode == jsu_pkg::M_ESC || dmode == jsu_pkg::M_HEX1 ||
          dmode == jsu_pkg::M_HEX2 || dmode == jsu_pkg::M_WANT_BS ||
          dmode == jsu_pkg::M_WANT_U)
        set_fail(jsu_pkg::ST_TRUNC);
      reset_decoder();
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].tail = 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + v;
    return ($urandom_range(1) ? "A" : "a") + v - 8'd10;
  endfunction

  function automatic void push_u(input logic [15:0] v);
    int k;
    str_q.push_back(jsu_pkg::CH_BSL);
    str_q.push_back(jsu_pkg::CH_U);
    for (k = 3; k >= 0; k--) str_q.push_back(hex_char(v[4*k +: 4]));
  endfunction

  function automatic logic [15:0] rand_high();
    if ($urandom_range(4) == 0) return $urandom_range(1) ? 16'hD800 : 16'hDBFF;
    return 16'hD800 | 16'($urandom_range(16'h3FF));
  endfunction

  function automatic logic [15:0] rand_low();
    if ($urandom_range(4) == 0) return $urandom_range(1) ? 16'hDC00 : 16'hDFFF;
    return 16'hDC00 | 16'($urandom_range(16'h3FF));
  endfunction

  // random string body, mostly well formed, sometimes with a broken tail
  task automatic build_string();
    int         tokens;
    int         pick;
    int         cut;
    bit         ok;
    logic [15:0] v;
    logic [7:0] c;
    logic [15:0] limit_cp [0:5];
    limit_cp = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    str_q.delete();
    if ($urandom_range(99) < 8) begin
      // pure noise
      repeat ($urandom_range(1, 8)) str_q.push_back(8'($urandom_range(255)));
    end else begin
      tokens = $urandom_range(1, 5);
      repeat (tokens) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          c = 8'($urandom_range(255));
          if (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL) c = c ^ 8'h80;
          str_q.push_back(c);
        end else if (pick < 50) begin
          str_q.push_back(jsu_pkg::CH_BSL);
          str_q.push_back(esc_set[$urandom_range(7)]);
        end else if (pick < 72) begin
          case ($urandom_range(3))
            0: v = 16'($urandom_range(16'h7F));
            1: v = 16'($urandom_range(16'h7FF, 16'h80));
            2: begin
              v = 16'($urandom_range(16'hFFFF, 16'h800));
              if (v[15:10] == 6'b110110) v[13] = 1'b0;
            end
            default: v = limit_cp[$urandom_range(5)];
          endcase
          push_u(v);
        end else if (pick < 92) begin
          // surrogate pair, now and then with a second half out of range
          push_u(rand_high());
          push_u(($urandom_range(9) == 0) ? 16'($urandom) : rand_low());
        end else begin
          push_u(rand_low());
        end
      end
      pick = $urandom_range(99);
      if (pick >= 60) begin
        case (pick % 5)
          0: begin
            str_q.push_back(jsu_pkg::CH_BSL);
            do c = 8'($urandom_range(255));
            while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_SLASH ||
                   c == jsu_pkg::CH_BSL || c == jsu_pkg::CH_B ||
                   c == jsu_pkg::CH_F || c == jsu_pkg::CH_N ||
                   c == jsu_pkg::CH_R || c == jsu_pkg::CH_T ||
                   c == jsu_pkg::CH_U);
            str_q.push_back(c);
          end
          1: begin
            if ($urandom_range(1)) push_u(rand_high());
            str_q.push_back(jsu_pkg::CH_BSL);
            str_q.push_back(jsu_pkg::CH_U);
            repeat ($urandom_range(3)) str_q.push_back(hex_char(4'($urandom_range(15))));
            do begin
              c = 8'($urandom_range(255));
              void'(hex_of(c, ok));
            end while (ok);
            str_q.push_back(c);
          end
          2: begin
            push_u(rand_high());
            if ($urandom_range(1)) begin
              do c = 8'($urandom_range(255)); while (c == jsu_pkg::CH_BSL);
            end else begin
              str_q.push_back(jsu_pkg::CH_BSL);
              do c = 8'($urandom_range(255)); while (c == jsu_pkg::CH_U);
            end
            str_q.push_back(c);
          end
          3: str_q.push_back(jsu_pkg::CH_QUOTE);
          default: begin
            // string ends inside an escape
            cut = $urandom_range(4);
            if (cut >= 2) push_u(rand_high());
            if (cut != 2) str_q.push_back(jsu_pkg::CH_BSL);
            if (cut == 1 || cut == 4) begin
              str_q.push_back(jsu_pkg::CH_U);
              repeat ($urandom_range(3)) str_q.push_back(hex_char(4'($urandom_range(15))));
            end
          end
        endcase
        // bytes after a quote or an error are ignored
        if (pick % 5 != 4) repeat ($urandom_range(2)) str_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // offer one word, wait for the handshake, record the prediction
  task automatic send_word(input logic [7:0] b, input logic l, input logic typed,
                           input word_t exp_w);
    if (!calm && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, l);
    if (typed) decoded_q.push_back(exp_w);
    else foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endtask

  // stimulus
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    reset_decoder();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 30; i++)
      send_word(dir_tab[i].data, dir_tab[i].eos, dir_tab[i].typed, dir_tab[i].exp_w);

    while (live_items < ITEMS) begin
      build_string();
      foreach (str_q[i]) begin
        calm = (live_items >= 120 && live_items < 170);
        if (!pressed && live_items >= 60) begin
          hold_req = 1'b1;
          pressed  = 1'b1;
        end
        send_word(str_q[i], i == str_q.size() - 1, 1'b0, NOEXP);
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errs == 0 && decoded_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // result side throttle, with one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 28);
      end
    end
  end

  // compare each accepted word with the oldest prediction
  always @(posedge clk) begin : mon
    word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected word: out_byte %02h, tuser %h, last %b",
               out_tdata, out_tuser, out_tlast);
        errs++;
      end else begin
        w = decoded_q.pop_front();
        if (out_tdata !== w.data) begin
          $error("out_byte: expected %02h, got %02h", w.data, out_tdata);
          errs++;
        end
        if (out_tuser[0] !== w.vld) begin
          $error("out_valid: expected %b, got %b", w.vld, out_tuser[0]);
          errs++;
        end
        if (out_tuser[3:1] !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_tuser[3:1]);
          errs++;
        end
        if (out_tlast !== w.tail) begin
          $error("last: expected %b, got %b", w.tail, out_tlast);
          errs++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
+incdir+design
design/jsu_pkg.sv
design/json_string_unescape_utf8_top.sv
tb/tb_json_string_unescape_utf8_top.sv
